/* rtl/adv_pkg.sv */
package adv_pkg;

  // Scheme constants.
  localparam int VELOCITY_HALF_RANGE = 5;
  localparam int VELOCITY_COUNT      = 11;
  localparam int FRACTION_BITS       = 16;

  // Fixed field widths.
  localparam int VEL_W  = 4;
  localparam int CELL_W = 17;
  localparam int DIFF_W = CELL_W + 1;

  localparam logic [CELL_W-1:0] ONE_Q16 = CELL_W'(65536);

  // Largest Courant magnitude, rounded half away from zero.
  localparam longint GAMMA_MAX =
    ((longint'(2 * VELOCITY_HALF_RANGE) << FRACTION_BITS) + longint'(VELOCITY_COUNT / 2))
    / longint'(VELOCITY_COUNT);
  localparam int GMAG_W  = $clog2(GAMMA_MAX + 1);
  localparam int GAMMA_W = GMAG_W + 1;
  localparam int MAG_W   = (VELOCITY_HALF_RANGE > 1) ? $clog2(VELOCITY_HALF_RANGE + 1) : 1;

  // Half the velocity count, added before dividing to round half away from zero.
  localparam longint HALF_COUNT = longint'(VELOCITY_COUNT / 2);

  // Datapath widths for the update t = u * 2^F - gamma * d.
  localparam int PROD_W = GAMMA_W + DIFF_W;
  localparam int T_W    = ((CELL_W + FRACTION_BITS > PROD_W) ?
                           (CELL_W + FRACTION_BITS) : PROD_W) + 2;

  // Queue sizes.
  localparam int CMDQ_DEPTH = 4;
  localparam int CMDQ_AW    = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CW    = $clog2(CMDQ_DEPTH + 1);
  localparam int OUTQ_DEPTH = 4;
  localparam int OUTQ_AW    = $clog2(OUTQ_DEPTH);
  localparam int OUTQ_CW    = $clog2(OUTQ_DEPTH + 1);

  // Courant magnitude table, indexed by the clamped velocity magnitude.
  typedef logic [VELOCITY_HALF_RANGE:0][GMAG_W-1:0] gamma_tab_t;

  // Quotient by the velocity count, worked out bit by bit at elaboration.
  function automatic longint div_by_count(longint num);
    longint quo;
    longint rem;
    quo = 0;
    rem = 0;
    for (int b = 62; b >= 0; b--) begin
      rem = (rem <<< 1) | ((num >>> b) & longint'(1));
      if (rem >= longint'(VELOCITY_COUNT)) begin
        rem = rem - longint'(VELOCITY_COUNT);
        quo = quo | (longint'(1) <<< b);
      end
    end
    return quo;
  endfunction

  function automatic gamma_tab_t gamma_table();
    gamma_tab_t tab;
    longint     num;
    for (int m = 0; m <= VELOCITY_HALF_RANGE; m++) begin
      num    = longint'(2 * m) << FRACTION_BITS;
      tab[m] = GMAG_W'(div_by_count(num + HALF_COUNT));
    end
    return tab;
  endfunction

  localparam gamma_tab_t GAMMA_TABLE = gamma_table();

  // Input transaction.
  typedef struct packed {
    logic signed [VEL_W-1:0] velocity;
    logic [CELL_W-1:0]       cell_value;
    logic                    last_in_row;
  } cell_item_t;

  // Result transaction.
  typedef struct packed {
    logic [CELL_W-1:0] new_value;
    logic              row_end;
    logic              last_of_run;
  } result_t;

  // Work for the back end: an optional computed result, then an optional
  // pass-through of the row's final cell.
  typedef struct packed {
    logic                      has_a;
    logic [CELL_W-1:0]         a_base;
    logic signed [DIFF_W-1:0]  a_diff;
    logic signed [GAMMA_W-1:0] gamma;
    logic                      a_row_end;
    logic                      a_last;
    logic                      has_b;
    logic [CELL_W-1:0]         b_value;
  } cmd_t;

  // Which half of a command the back end issues next.
  typedef enum logic {
    PH_FIRST,
    PH_SECOND
  } issue_phase_t;

endpackage

/* rtl/upwind_advection_row_stepper_top.sv */
// Channel   Direction  Handshake               Payload
// -------   ---------  ---------               -------
// cells     in         push / full             cell_item (velocity, cell_value, last_in_row)
// results   out        pop / empty             result (new_value, row_end, last_of_run)
//
// One cell transaction is taken per cycle while full is low; its work passes
// through the command queue and the product stage into the output queue.
// The single multiplier issues one result per cycle while the output queue has
// room; the final cell of a leftward row gives two results, issued one after the other.
// A four-entry command queue decouples the front end from the back end, and a
// four-entry output queue lets results wait while new cells are still taken.
// Reset is synchronous and empties both queues and clears the held cell.
// full rises only when the command queue fills, as under a long output stall.
module upwind_advection_row_stepper_top (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  output logic                full,
  input  adv_pkg::cell_item_t cell_item,
  output logic                empty,
  input  logic                pop,
  output adv_pkg::result_t    result
);
  import adv_pkg::*;

  logic cmd_push;
  cmd_t cmd_in;
  logic cmd_valid;
  logic cmd_pop;
  cmd_t cmd_head;

  // Front end: clamps, looks up gamma and classifies each transaction.
  adv_front u_front (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cell_item (cell_item),
    .cmd_push  (cmd_push),
    .cmd       (cmd_in)
  );

  // Command queue between the two halves.
  adv_cmdq u_cmdq (
    .clk    (clk),
    .rst    (rst),
    .wr     (cmd_push),
    .wr_cmd (cmd_in),
    .full   (full),
    .rd     (cmd_pop),
    .valid  (cmd_valid),
    .head   (cmd_head)
  );

  // Back end: multiply, round, saturate and queue the results.
  adv_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd       (cmd_head),
    .cmd_pop   (cmd_pop),
    .pop       (pop),
    .empty     (empty),
    .result    (result)
  );

`ifndef SYNTHESIS
  // A command always carries at least one result.
  a_cmd_has_work: assert property (@(posedge clk) disable iff (rst)
    cmd_push |-> (cmd_in.has_a || cmd_in.has_b))
    else $error("command pushed without any result");

  // A row's final result always closes the run of its transaction.
  a_row_end_last: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.row_end) |-> result.last_of_run)
    else $error("row end result not marked as last of run");

  // Results stay within the range zero to one.
  a_value_range: assert property (@(posedge clk) disable iff (rst)
    !empty |-> (result.new_value <= ONE_Q16))
    else $error("result above one");

  // A command is only popped while one is waiting.
  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    cmd_pop |-> cmd_valid)
    else $error("command queue popped while empty");
`endif

endmodule

/* rtl/adv_front.sv */
module adv_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic                full,
  input  adv_pkg::cell_item_t cell_item,
  output logic                cmd_push,
  output adv_pkg::cmd_t       cmd
);
  import adv_pkg::*;

  logic                      accept;
  logic                      vel_neg;
  logic                      vel_pos;
  logic [VEL_W-1:0]          vel_abs;
  logic [MAG_W-1:0]          vel_mag;
  logic [GMAG_W-1:0]         gamma_mag;
  logic signed [GAMMA_W-1:0] gamma;
  logic [CELL_W-1:0]         u;
  logic signed [DIFF_W-1:0]  diff;
  logic [CELL_W-1:0]         held_cell;
  logic                      held_valid;

  assign accept = push && !full;

  // Clamp the velocity and look up the signed Courant number.
  assign vel_neg = cell_item.velocity[VEL_W-1];
  assign vel_pos = !vel_neg && (cell_item.velocity != '0);
  assign vel_abs = vel_neg ? VEL_W'(-cell_item.velocity) : VEL_W'(cell_item.velocity);

  always_comb begin
    if (int'(vel_abs) > VELOCITY_HALF_RANGE) begin
      vel_mag = MAG_W'(VELOCITY_HALF_RANGE);
    end else begin
      vel_mag = MAG_W'(vel_abs);
    end
  end

  assign gamma_mag = GAMMA_TABLE[vel_mag];
  assign gamma     = vel_neg ? -$signed({1'b0, gamma_mag}) : $signed({1'b0, gamma_mag});

  // Saturate the cell to one and form the difference to the held cell.
  assign u    = (cell_item.cell_value > ONE_Q16) ? ONE_Q16 : cell_item.cell_value;
  assign diff = $signed({1'b0, u}) - $signed({1'b0, held_cell});

  // Classify the transaction into work for the back end.
  always_comb begin
    cmd.gamma   = gamma;
    cmd.b_value = u;
    if (vel_pos) begin
      cmd.has_a     = 1'b1;
      cmd.a_base    = u;
      cmd.a_diff    = held_valid ? diff : '0;
      cmd.a_row_end = cell_item.last_in_row;
      cmd.a_last    = 1'b1;
      cmd.has_b     = 1'b0;
    end else begin
      cmd.has_a     = held_valid;
      cmd.a_base    = held_cell;
      cmd.a_diff    = diff;
      cmd.a_row_end = 1'b0;
      cmd.a_last    = !cell_item.last_in_row;
      cmd.has_b     = cell_item.last_in_row;
    end
  end

  // A first cell of a leftward row gives no work yet.
  assign cmd_push = accept && (cmd.has_a || cmd.has_b);

  // Keep the previous cell of the current row.
  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
      held_cell  <= '0;
    end else if (accept) begin
      held_valid <= !cell_item.last_in_row;
      held_cell  <= u;
    end
  end

endmodule

/* rtl/adv_cmdq.sv */
module adv_cmdq (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr,
  input  adv_pkg::cmd_t wr_cmd,
  output logic          full,
  input  logic          rd,
  output logic          valid,
  output adv_pkg::cmd_t head
);
  import adv_pkg::*;

  cmd_t               slots [CMDQ_DEPTH];
  logic [CMDQ_AW-1:0] wptr;
  logic [CMDQ_AW-1:0] rptr;
  logic [CMDQ_CW-1:0] count;
  logic               do_wr;
  logic               do_rd;

  assign full  = (count == CMDQ_CW'(CMDQ_DEPTH));
  assign valid = (count != '0);
  assign head  = slots[rptr];
  assign do_wr = wr && !full;
  assign do_rd = rd && valid;

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (do_wr) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + CMDQ_CW'(do_wr) - CMDQ_CW'(do_rd);
    end
  end

  // Command storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wptr] <= wr_cmd;
    end
  end

endmodule

/* rtl/adv_back.sv */
module adv_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             cmd_valid,
  input  adv_pkg::cmd_t    cmd,
  output logic             cmd_pop,
  input  logic             pop,
  output logic             empty,
  output adv_pkg::result_t result
);
  import adv_pkg::*;

  issue_phase_t              phase;
  issue_phase_t              phase_next;
  logic                      issue_a;
  logic                      last_op;
  logic                      can_issue;
  logic                      issue;
  logic [CELL_W-1:0]         op_base;
  logic signed [GAMMA_W-1:0] op_gamma;
  logic signed [DIFF_W-1:0]  op_diff;
  logic                      op_row_end;
  logic                      op_last;
  logic signed [PROD_W-1:0]  op_prod;

  logic                      s1_valid;
  logic [CELL_W-1:0]         s1_base;
  logic signed [PROD_W-1:0]  s1_prod;
  logic                      s1_row_end;
  logic                      s1_last;

  localparam logic [T_W-1:0] ROUND_HALF = T_W'(1) << (FRACTION_BITS - 1);

  logic signed [T_W-1:0]         t_full;
  logic [T_W-1:0]                t_round;
  logic [T_W-FRACTION_BITS-1:0]  rounded;
  logic [CELL_W-1:0]             value;
  result_t                       res_wr;

  result_t            outq [OUTQ_DEPTH];
  logic [OUTQ_AW-1:0] wptr;
  logic [OUTQ_AW-1:0] rptr;
  logic [OUTQ_CW-1:0] count;
  logic               do_rd;

  // Issue only while the output queue has room for everything in flight.
  assign can_issue = cmd_valid &&
                     ((OUTQ_CW + 1)'(count) + (OUTQ_CW + 1)'(s1_valid) <
                      (OUTQ_CW + 1)'(OUTQ_DEPTH));
  assign issue_a   = (phase == PH_FIRST) && cmd.has_a;
  assign last_op   = !issue_a || !cmd.has_b;
  assign issue     = can_issue;

  // Next phase of the command being issued.
  always_comb begin
    phase_next = phase;
    if (issue) begin
      phase_next = last_op ? PH_FIRST : PH_SECOND;
    end
  end

  // Operands of the issued operation: a pass-through runs with zero gamma.
  always_comb begin
    cmd_pop = issue && last_op;
    if (issue_a) begin
      op_base    = cmd.a_base;
      op_gamma   = cmd.gamma;
      op_diff    = cmd.a_diff;
      op_row_end = cmd.a_row_end;
      op_last    = cmd.a_last;
    end else begin
      op_base    = cmd.b_value;
      op_gamma   = '0;
      op_diff    = '0;
      op_row_end = 1'b1;
      op_last    = 1'b1;
    end
  end

  assign op_prod = op_gamma * op_diff;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_FIRST;
      s1_valid <= 1'b0;
    end else begin
      phase    <= phase_next;
      s1_valid <= issue;
    end
  end

  // Product stage.
  always_ff @(posedge clk) begin
    if (issue) begin
      s1_base    <= op_base;
      s1_prod    <= op_prod;
      s1_row_end <= op_row_end;
      s1_last    <= op_last;
    end
  end

  // Subtract, round half up and saturate to the range zero to one.
  assign t_full  = $signed({{(T_W - CELL_W - FRACTION_BITS){1'b0}}, s1_base,
                            {FRACTION_BITS{1'b0}}}) - T_W'(s1_prod);
  assign t_round = $unsigned(t_full) + ROUND_HALF;
  assign rounded = t_round[T_W-1:FRACTION_BITS];

  always_comb begin
    if (t_full[T_W-1]) begin
      value = '0;
    end else if (rounded > (T_W - FRACTION_BITS)'(ONE_Q16)) begin
      value = ONE_Q16;
    end else begin
      value = rounded[CELL_W-1:0];
    end
  end

  assign res_wr.new_value   = value;
  assign res_wr.row_end     = s1_row_end;
  assign res_wr.last_of_run = s1_last;

  // Output queue: room is reserved at issue time, so writes never overflow.
  assign empty  = (count == '0);
  assign result = outq[rptr];
  assign do_rd  = pop && !empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (s1_valid) begin
        wptr <= wptr + 1'b1;
      end
      if (do_rd) begin
        rptr <= rptr + 1'b1;
      end
      count <= count + OUTQ_CW'(s1_valid) - OUTQ_CW'(do_rd);
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      outq[wptr] <= res_wr;
    end
  end

endmodule

/* dv/tb.sv */
`timescale 1ns / 100ps

module tb;
  import adv_pkg::*;

  // Directed rows either carry their typed results or defer to the predictor.
  localparam int USE_PREDICTOR = -1;
  localparam int DIR_ROWS      = 23;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int MAX_REPORTS   = 10;
  localparam int DRAIN_CYCLES  = 16;
  localparam result_t NO_RESULT = '0;

  typedef struct {
    int      vel;
    int      cell_val;
    bit      last;
    int      n_typed;
    result_t r0;
    result_t r1;
  } dir_row_t;

  typedef struct {
    cell_item_t item;
    int         n_typed;
    result_t    r0;
    result_t    r1;
  } cell_case_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       push = 1'b0;
  logic       full;
  cell_item_t cell_item = '0;
  logic       empty;
  logic       pop = 1'b0;
  result_t    result;

  // Predictor state: the previous cell of the current row.
  logic [CELL_W-1:0] held_cell = '0;
  logic              held_valid = 1'b0;

  cell_case_t cases[$];
  result_t    owed_results[$];
  int         accepted_cells = 0;
  int         fail_count = 0;
  int         owed_n;
  result_t    owed_a;
  result_t    owed_b;
  int         rx_mode = 0;
  int         rx_left = 0;

  // Directed rows: extremes, both branches, clamping and sign changes in a row.
  dir_row_t dir_tab [DIR_ROWS] = '{
    '{ 3,      0, 1'b0, 1, '{17'd0, 1'b0, 1'b1}, NO_RESULT},
    '{ 3,  65536, 1'b0, USE_PREDICTOR, NO_RESULT, NO_RESULT},
    '{ 3,   1000, 1'b1, USE_PREDICTOR, NO_RESULT, NO_RESULT},
    '{ 5, 131071, 1'b1, 1, '{17'd65536, 1'b1, 1'b1}, NO_RESULT},
    '{ 0,  20000, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{ 0,  30000, 1'b0, 1, '{17'd20000, 1'b0, 1'b1}, NO_RESULT},
    '{ 0,  40000, 1'b1, 2, '{17'd30000, 1'b0, 1'b0}, '{17'd40000, 1'b1, 1'b1}},
    '{-5,  65536, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{-5,      0, 1'b0, USE_PREDICTOR, NO_RESULT, NO_RESULT},
    '{-5,  65536, 1'b1, USE_PREDICTOR, NO_RESULT, NO_RESULT},
    '{-8,  12345, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{ 7,  50000, 1'b0, USE_PREDICTOR, NO_RESULT, NO_RESULT},
    '{-1,  65535, 1'b0, USE_PREDICTOR, NO_RESULT, NO_RESULT},
    '{ 1,      1, 1'b1, USE_PREDICTOR, NO_RESULT, NO_RESULT},
    '{-6, 131071, 1'b1, 1, '{17'd65536, 1'b1, 1'b1}, NO_RESULT},
    '{ 2,  65537, 1'b0, 1, '{17'd65536, 1'b0, 1'b1}, NO_RESULT},
    '{ 2,      0, 1'b0, USE_PREDICTOR, NO_RESULT, NO_RESULT},
    '{-4,  65536, 1'b0, USE_PREDICTOR, NO_RESULT, NO_RESULT},
    '{-4,      0, 1'b1, USE_PREDICTOR, NO_RESULT, NO_RESULT},
    '{ 5,      0, 1'b0, 1, '{17'd0, 1'b0, 1'b1}, NO_RESULT},
    '{ 5,  65536, 1'b1, USE_PREDICTOR, NO_RESULT, NO_RESULT},
    '{-2,      7, 1'b0, 0, NO_RESULT, NO_RESULT},
    '{-2,  65536, 1'b1, USE_PREDICTOR, NO_RESULT, NO_RESULT}
  };

  upwind_advection_row_stepper_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .full      (full),
    .cell_item (cell_item),
    .empty     (empty),
    .pop       (pop),
    .result    (result)
  );

  // Clock generation.
  initial begin
    forever #5 clk = ~clk;
  end

  // Courant number in fixed point, rounded half away from zero.
  function automatic longint courant_fixed(int p);
    longint mag;
    longint g;
    mag = (p < 0) ? -p : p;
    g = (((mag * 2) <<< FRACTION_BITS) + VELOCITY_COUNT / 2) / VELOCITY_COUNT;
    return (p < 0) ? -g : g;
  endfunction

  // u - gamma*d, rounded half up and saturated to [0, 1.0].
  function automatic logic [CELL_W-1:0] upwind_update(longint u, longint g, longint d);
    longint t;
    longint r;
    t = (u <<< FRACTION_BITS) - g * d;
    if (t < 0) begin
      return '0;
    end
    r = (t + (longint'(1) <<< (FRACTION_BITS - 1))) >>> FRACTION_BITS;
    if (r > longint'(ONE_Q16)) begin
      r = longint'(ONE_Q16);
    end
    return CELL_W'(r);
  endfunction

  // Advances the held cell by one input and returns the results it causes.
  function automatic int advect_cell(input cell_item_t it, output result_t ra,
                                     output result_t rb);
    int      p;
    longint  u;
    longint  g;
    int      n;
    result_t pass;
    p = $signed(it.velocity);
    u = longint'(it.cell_value);
    if (u > longint'(ONE_Q16)) begin
      u = longint'(ONE_Q16);
    end
    if (p > VELOCITY_HALF_RANGE) begin
      p = VELOCITY_HALF_RANGE;
    end
    if (p < -VELOCITY_HALF_RANGE) begin
      p = -VELOCITY_HALF_RANGE;
    end
    g = courant_fixed(p);
    ra = '0;
    rb = '0;
    n = 0;
    if (p > 0) begin
      // Rightward flow: the left neighbour is the held cell, if any.
      ra.new_value = held_valid ? upwind_update(u, g, u - longint'(held_cell))
                                : CELL_W'(u);
      ra.row_end = it.last_in_row;
      ra.last_of_run = 1'b1;
      n = 1;
    end else begin
      // Leftward or no flow: the held cell is updated now that its right
      // neighbour has arrived, and a final cell passes through.
      if (held_valid) begin
        ra.new_value = upwind_update(longint'(held_cell), g, u - longint'(held_cell));
        ra.row_end = 1'b0;
        ra.last_of_run = !it.last_in_row;
        n = 1;
      end
      if (it.last_in_row) begin
        pass.new_value = CELL_W'(u);
        pass.row_end = 1'b1;
        pass.last_of_run = 1'b1;
        if (n == 0) begin
          ra = pass;
        end else begin
          rb = pass;
        end
        n++;
      end
    end
    held_cell = CELL_W'(u);
    held_valid = !it.last_in_row;
    return n;
  endfunction

  function automatic void note_failure(string msg);
    fail_count++;
    if (fail_count <= MAX_REPORTS) begin
      $display("%s", msg);
    end
  endfunction

  // Stimulus build, cell driver and end of run.
  initial begin
    cell_case_t c;
    int         row_len;
    int         row_vel;
    int         burst_left;
    int         gap;

    // Directed table first.
    foreach (dir_tab[i]) begin
      c.item.velocity = VEL_W'(dir_tab[i].vel);
      c.item.cell_value = CELL_W'(dir_tab[i].cell_val);
      c.item.last_in_row = dir_tab[i].last;
      c.n_typed = dir_tab[i].n_typed;
      c.r0 = dir_tab[i].r0;
      c.r1 = dir_tab[i].r1;
      cases.push_back(c);
    end

    // Random rows: mostly short rows of one velocity, some long ones, with
    // occasional velocity changes and early row ends mixed in.
    while (cases.size() < DIR_ROWS + RANDOM_ITEMS) begin
      row_len = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      row_vel = $urandom_range(0, 15);
      for (int k = 0; k < row_len; k++) begin
        c.item.velocity = VEL_W'(($urandom_range(0, 11) == 0) ? $urandom_range(0, 15)
                                                               : row_vel);
        case ($urandom_range(0, 15))
          0:       c.item.cell_value = '0;
          1:       c.item.cell_value = ONE_Q16;
          2:       c.item.cell_value = CELL_W'($urandom_range(65537, 131071));
          3:       c.item.cell_value = CELL_W'($urandom_range(65500, 65536));
          4:       c.item.cell_value = CELL_W'($urandom_range(0, 40));
          default: c.item.cell_value = CELL_W'($urandom_range(0, 65536));
        endcase
        c.item.last_in_row = (k == row_len - 1) || ($urandom_range(0, 19) == 0);
        c.n_typed = USE_PREDICTOR;
        c.r0 = NO_RESULT;
        c.r1 = NO_RESULT;
        cases.push_back(c);
      end
    end

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Bursts of back-to-back cells separated by random gaps.
    burst_left = $urandom_range(1, 60);
    foreach (cases[i]) begin
      cell_item <= cases[i].item;
      push <= 1'b1;
      @(posedge clk);
      while (full) @(posedge clk);
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 60);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        if (gap > 0) begin
          push <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end else begin
        burst_left--;
      end
    end
    push <= 1'b0;

    // Drain, then allow time for any stray results to show.
    @(posedge clk);
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

  // Result receiver: switches between free flow, random stalls, long stalls
  // and a periodic pattern.
  always @(posedge clk) begin
    if (rst) begin
      pop <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = $urandom_range(0, 3);
        rx_left = $urandom_range(20, 200);
      end
      rx_left--;
      case (rx_mode)
        0:       pop <= 1'b1;
        1:       pop <= 1'($urandom_range(0, 1));
        2:       pop <= ($urandom_range(0, 7) == 0);
        default: pop <= (rx_left % 3 == 0);
      endcase
    end
  end

  // Prediction on each accepted cell transaction and checking of each
  // accepted result transaction against the oldest expectation.
  always @(posedge clk) begin
    if (!rst) begin
      if (push && !full) begin
        owed_n = advect_cell(cell_item, owed_a, owed_b);
        if (accepted_cells < cases.size() && cases[accepted_cells].n_typed != USE_PREDICTOR) begin
          owed_n = cases[accepted_cells].n_typed;
          owed_a = cases[accepted_cells].r0;
          owed_b = cases[accepted_cells].r1;
        end
        if (owed_n > 0) owed_results.push_back(owed_a);
        if (owed_n > 1) owed_results.push_back(owed_b);
        accepted_cells++;
      end
      if (pop && !empty) begin
        if (owed_results.size() == 0) begin
          note_failure($sformatf("unexpected result: value=%0d end=%0b last=%0b",
                                 result.new_value, result.row_end, result.last_of_run));
        end else begin
          owed_a = owed_results.pop_front();
          if (result.new_value !== owed_a.new_value || result.row_end !== owed_a.row_end ||
              result.last_of_run !== owed_a.last_of_run) begin
            note_failure($sformatf(
              "result mismatch: expected value=%0d end=%0b last=%0b, got value=%0d end=%0b last=%0b",
              owed_a.new_value, owed_a.row_end, owed_a.last_of_run,
              result.new_value, result.row_end, result.last_of_run));
          end
        end
      end
    end
  end

  // Overall time limit.
  initial begin
    #5000000;
    $display("tb NOT OK");
    $finish;
  end

endmodule

/* filelist.f */
rtl/adv_pkg.sv
rtl/adv_front.sv
rtl/adv_cmdq.sv
rtl/adv_back.sv
rtl/upwind_advection_row_stepper_top.sv
dv/tb.sv
